// ----- rtl/vfvc_pkg.sv -----
package vfvc_pkg;

   // Default chunk geometry: 32 voxels along an edge, 8-bit voxel types.
   localparam int COORD_BITS_DEF = 5;
   localparam int VOXEL_BITS_DEF = 8;

   // Request kinds carried on the request tuser bit.
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // Read sequence of one query. The neighbor codes follow each other so that
   // the sequencer can step through them with an increment.
   typedef logic [2:0] step_type;

   localparam step_type STEP_CENTRE = 3'd0;
   localparam step_type STEP_XP     = 3'd1;
   localparam step_type STEP_XN     = 3'd2;
   localparam step_type STEP_YP     = 3'd3;
   localparam step_type STEP_YN     = 3'd4;
   localparam step_type STEP_ZP     = 3'd5;
   localparam step_type STEP_ZN     = 3'd6;

endpackage

// ----- rtl/vfvc_store.sv -----
module vfvc_store #(
   parameter int ADDR_BITS = 15,
   parameter int DATA_BITS = 8
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] addr,
   input  logic [DATA_BITS-1:0] wr_data,
   output logic [DATA_BITS-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_BITS;

   // Single-port voxel memory with a registered read. Contents are not reset.
   logic [DATA_BITS-1:0] store_ff [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/vfvc_ctrl.sv -----
module vfvc_ctrl #(
   parameter int COORD_BITS = vfvc_pkg::COORD_BITS_DEF,
   parameter int VOXEL_BITS = vfvc_pkg::VOXEL_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   // Decoded request.
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_mode,
   input  logic [COORD_BITS-1:0]   req_x,
   input  logic [COORD_BITS-1:0]   req_y,
   input  logic [COORD_BITS-1:0]   req_z,
   input  logic [VOXEL_BITS-1:0]   req_value,
   // Voxel memory port.
   output logic                    mem_wr_en,
   output logic                    mem_rd_en,
   output logic [3*COORD_BITS-1:0] mem_addr,
   output logic [VOXEL_BITS-1:0]   mem_wr_data,
   input  logic [VOXEL_BITS-1:0]   mem_rd_data,
   // Query result toward the output register.
   output logic                    res_valid,
   input  logic                    res_ready,
   output logic                    res_visible,
   output logic [VOXEL_BITS-1:0]   res_centre,
   output logic [COORD_BITS-1:0]   res_x,
   output logic [COORD_BITS-1:0]   res_y,
   output logic [COORD_BITS-1:0]   res_z
);

   import vfvc_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;
   localparam logic [1:0] ST_HOLD   = 2'd3;

   localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

   logic [1:0]            state_ff, state_in;
   step_type              step_ff, step_in;
   logic [COORD_BITS-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [VOXEL_BITS-1:0] centre_ff, centre_in;
   logic                  open_ff, open_in;
   logic                  rd_pend_ff, rd_pend_in;
   step_type              rd_step_ff, rd_step_in;

   logic                  accept;
   logic                  in_chunk;
   logic [COORD_BITS-1:0] nx, ny, nz;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Neighbor coordinate of the current step; a step past a face is outside.
   always_comb begin
      nx       = x_ff;
      ny       = y_ff;
      nz       = z_ff;
      in_chunk = 1'b1;
      case (step_ff)
         STEP_XP: begin
            if (x_ff == COORD_MAX) in_chunk = 1'b0;
            else nx = x_ff + 1'b1;
         end
         STEP_XN: begin
            if (x_ff == '0) in_chunk = 1'b0;
            else nx = x_ff - 1'b1;
         end
         STEP_YP: begin
            if (y_ff == COORD_MAX) in_chunk = 1'b0;
            else ny = y_ff + 1'b1;
         end
         STEP_YN: begin
            if (y_ff == '0) in_chunk = 1'b0;
            else ny = y_ff - 1'b1;
         end
         STEP_ZP: begin
            if (z_ff == COORD_MAX) in_chunk = 1'b0;
            else nz = z_ff + 1'b1;
         end
         STEP_ZN: begin
            if (z_ff == '0) in_chunk = 1'b0;
            else nz = z_ff - 1'b1;
         end
         default: begin
            in_chunk = 1'b1;
         end
      endcase
   end

   // The centre read goes out in the accept cycle straight from the request.
   always_comb begin
      mem_wr_data = req_value;
      if (state_ff == ST_IDLE) begin
         mem_addr  = {req_z, req_y, req_x};
         mem_wr_en = accept && (req_mode == MODE_WRITE);
         mem_rd_en = accept && (req_mode == MODE_QUERY);
      end else begin
         mem_addr  = {nz, ny, nx};
         mem_wr_en = 1'b0;
         mem_rd_en = (state_ff == ST_SCAN) && in_chunk;
      end
   end

   assign rd_pend_in = mem_rd_en;
   assign rd_step_in = (state_ff == ST_IDLE) ? STEP_CENTRE : step_ff;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      z_in      = z_ff;
      centre_in = centre_ff;
      open_in   = open_ff;

      // Fold in the read that was issued last cycle.
      if (rd_pend_ff) begin
         if (rd_step_ff == STEP_CENTRE) centre_in = mem_rd_data;
         else if (mem_rd_data == '0) open_in = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_mode == MODE_QUERY)) begin
               x_in     = req_x;
               y_in     = req_y;
               z_in     = req_z;
               open_in  = 1'b0;
               step_in  = STEP_XP;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!in_chunk) open_in = 1'b1;
            if (step_ff == STEP_ZN) state_in = ST_FINISH;
            else step_in = step_ff + 3'd1;
         end
         ST_FINISH, ST_HOLD: begin
            if (res_ready) state_in = ST_IDLE;
            else state_in = ST_HOLD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res_valid   = (state_ff == ST_FINISH) || (state_ff == ST_HOLD);
   assign res_visible = (centre_in != '0) && open_in;
   assign res_centre  = centre_in;
   assign res_x       = x_ff;
   assign res_y       = y_ff;
   assign res_z       = z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= rd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      rd_step_ff <= rd_step_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      z_ff       <= z_in;
      centre_ff  <= centre_in;
      open_ff    <= open_in;
   end

endmodule

// ----- rtl/voxel_face_visibility_cull_top.sv -----
// Voxel face visibility cull: one chunk of voxels in a single-port memory.
// A write transfer is taken whenever the block is idle. A query occupies the block:
// the voxel read and one read per in-chunk face neighbor share the one memory port,
// one per cycle, and the result is registered after the last neighbor step, or later
// while the output register cannot take it.
// Reset clears the control logic only; voxel memory contents stay undefined until written.
module voxel_face_visibility_cull_top #(
   parameter int COORD_BITS = vfvc_pkg::COORD_BITS_DEF,
   parameter int VOXEL_BITS = vfvc_pkg::VOXEL_BITS_DEF,
   localparam int REQ_BITS  = 3 * COORD_BITS + VOXEL_BITS,
   localparam int REQ_W     = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_BITS  = 1 + VOXEL_BITS + 3 * COORD_BITS,
   localparam int RSP_W     = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // Fields from bit 0 up: pos_x, pos_y, pos_z, voxel_value, zero fill.
   input  logic [REQ_W-1:0] req_tdata,
   // Field: mode (0 writes a voxel, 1 queries its visibility).
   input  logic             req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // Fields from bit 0 up: visible, vertex word (x, y, z, voxel value), zero fill.
   output logic [RSP_W-1:0] rsp_tdata
);

   import vfvc_pkg::*;

   logic [COORD_BITS-1:0]   req_x, req_y, req_z;
   logic [VOXEL_BITS-1:0]   req_value;

   logic                    mem_wr_en, mem_rd_en;
   logic [3*COORD_BITS-1:0] mem_addr;
   logic [VOXEL_BITS-1:0]   mem_wr_data, mem_rd_data;

   logic                    res_valid, res_ready, res_visible;
   logic [VOXEL_BITS-1:0]   res_centre;
   logic [COORD_BITS-1:0]   res_x, res_y, res_z;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]        rsp_data_ff, rsp_data_in;

   // Unpack the request transfer.
   assign req_x     = req_tdata[COORD_BITS-1:0];
   assign req_y     = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign req_z     = req_tdata[3*COORD_BITS-1:2*COORD_BITS];
   assign req_value = req_tdata[REQ_BITS-1:3*COORD_BITS];

   vfvc_ctrl #(
      .COORD_BITS(COORD_BITS),
      .VOXEL_BITS(VOXEL_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_mode    (req_tuser),
      .req_x       (req_x),
      .req_y       (req_y),
      .req_z       (req_z),
      .req_value   (req_value),
      .mem_wr_en   (mem_wr_en),
      .mem_rd_en   (mem_rd_en),
      .mem_addr    (mem_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_data (mem_rd_data),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_visible (res_visible),
      .res_centre  (res_centre),
      .res_x       (res_x),
      .res_y       (res_y),
      .res_z       (res_z)
   );

   vfvc_store #(
      .ADDR_BITS(3 * COORD_BITS),
      .DATA_BITS(VOXEL_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .rd_en   (mem_rd_en),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   // The output register takes a new result whenever it is empty or its
   // current transfer completes in the same cycle, so the sequencer is never
   // held up by a slow consumer unless a second result is already waiting.
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_W'({res_centre, res_z, res_y, res_x, res_visible});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- sim/tb_voxel_face_visibility_cull_top.sv -----
`timescale 1ns / 1ps

module tb_voxel_face_visibility_cull_top;
   import vfvc_pkg::*;

   // Chunk geometry follows the defaults that the block is built with.
   localparam int COORD_W = COORD_BITS_DEF;
   localparam int VOXEL_W = VOXEL_BITS_DEF;
   localparam int EDGE = 1 << COORD_W;
   localparam int CELLS = 1 << (3 * COORD_W);
   localparam int VERTEX_W = VOXEL_W + 3 * COORD_W;
   localparam int REQ_W = ((3 * COORD_W + VOXEL_W + 7) / 8) * 8;
   localparam int RSP_W = ((1 + VERTEX_W + 7) / 8) * 8;

   // A query holds the block only for its read sequence and result hand-off, so
   // a stretch of STALL_LIMIT without a single transfer means it has hung.
   localparam int STALL_LIMIT = 2000;
   localparam int ITEMS_PER_PHASE = 627;

   typedef struct packed {
      logic               mode;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic [VOXEL_W-1:0] value;
   } voxel_req_type;

   typedef struct packed {
      logic                visible;
      logic [VERTEX_W-1:0] vertex_word;
   } cull_result_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   // Fields from bit 0 up: pos_x, pos_y, pos_z, voxel_value, zero fill.
   logic [REQ_W-1:0] req_tdata = '0;
   // Field: mode (0 writes a voxel, 1 queries its visibility).
   logic             req_tuser = MODE_WRITE;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   // Fields from bit 0 up: visible, vertex word (x, y, z, voxel value), zero fill.
   logic [RSP_W-1:0] rsp_tdata;

   // Items waiting to be driven, filled by the stimulus process.
   voxel_req_type   pending_reqs[$];
   // Culling outcomes that the block still owes, oldest first.
   cull_result_type vertex_due[$];

   // Mirror of the voxel memory as seen through accepted write transfers.
   logic [VOXEL_W-1:0] chunk_mirror[CELLS];
   // Cells that the stimulus has already scheduled a write for. Queries are
   // only generated where the voxel and every in-chunk neighbor are covered,
   // because the memory holds no defined value before its first write.
   bit cell_filled[CELLS];

   int send_idle_pct = 25;
   int recv_idle_pct = 46;
   bit req_fire = 1'b0;
   int quiet_cycles = 0;
   int errors = 0;
   int n_writes = 0;
   int n_queries = 0;
   int n_visible = 0;

   // Corner of the small box in which the random part concentrates its work.
   int win_x, win_y, win_z;

   voxel_face_visibility_cull_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int cell_index(input int x, input int y, input int z);
      return (z << (2 * COORD_W)) | (y << COORD_W) | x;
   endfunction

   // Voxel held at a possibly out-of-chunk position; outside reads as empty.
   function automatic logic [VOXEL_W-1:0] cell_at(input int x, input int y, input int z);
      if (x < 0 || y < 0 || z < 0 || x >= EDGE || y >= EDGE || z >= EDGE) begin
         return '0;
      end
      return chunk_mirror[cell_index(x, y, z)];
   endfunction

   // Expected answer to a query: the voxel is visible when it is solid and at
   // least one of its six faces touches an empty cell.
   function automatic cull_result_type cull_outcome(input int x, input int y, input int z);
      cull_result_type outcome;
      logic [VOXEL_W-1:0] centre;
      logic open_face;
      centre = cell_at(x, y, z);
      open_face = cell_at(x + 1, y, z) == '0 || cell_at(x - 1, y, z) == '0 ||
                  cell_at(x, y + 1, z) == '0 || cell_at(x, y - 1, z) == '0 ||
                  cell_at(x, y, z + 1) == '0 || cell_at(x, y, z - 1) == '0;
      outcome.visible = (centre != '0) && open_face;
      outcome.vertex_word = {centre, z[COORD_W-1:0], y[COORD_W-1:0], x[COORD_W-1:0]};
      return outcome;
   endfunction

   function automatic bit covered_or_outside(input int x, input int y, input int z);
      if (x < 0 || y < 0 || z < 0 || x >= EDGE || y >= EDGE || z >= EDGE) begin
         return 1'b1;
      end
      return cell_filled[cell_index(x, y, z)];
   endfunction

   function automatic bit queryable(input int x, input int y, input int z);
      return covered_or_outside(x, y, z) &&
             covered_or_outside(x + 1, y, z) && covered_or_outside(x - 1, y, z) &&
             covered_or_outside(x, y + 1, z) && covered_or_outside(x, y - 1, z) &&
             covered_or_outside(x, y, z + 1) && covered_or_outside(x, y, z - 1);
   endfunction

   // Window corners favor the chunk faces so that out-of-chunk neighbors
   // are exercised often.
   function automatic int window_origin();
      case ($urandom_range(3))
         0: return 0;
         1: return EDGE - 4;
         default: return $urandom_range(EDGE - 4);
      endcase
   endfunction

   task automatic queue_write(input int x, input int y, input int z, input int value);
      voxel_req_type item;
      item.mode = MODE_WRITE;
      item.x = COORD_W'(x);
      item.y = COORD_W'(y);
      item.z = COORD_W'(z);
      item.value = VOXEL_W'(value);
      cell_filled[cell_index(x, y, z)] = 1'b1;
      pending_reqs.insert(pending_reqs.size(), item);
   endtask

   // The value field is ignored on a query, so it carries random bits.
   task automatic queue_query(input int x, input int y, input int z);
      voxel_req_type item;
      item.mode = MODE_QUERY;
      item.x = COORD_W'(x);
      item.y = COORD_W'(y);
      item.z = COORD_W'(z);
      item.value = VOXEL_W'($urandom_range((1 << VOXEL_W) - 1));
      pending_reqs.insert(pending_reqs.size(), item);
   endtask

   // Random traffic. Work is concentrated in a 4x4x4 window that moves now
   // and then; writes fill it (about a third of them with empty voxels) and
   // queries land on cells whose whole neighborhood is defined. When no such
   // cell turns up, the item becomes a write that extends the filled area.
   // A few writes go anywhere in the chunk so every coordinate bit toggles.
   task automatic fill_random(input int count);
      int n, r, tries, cx, cy, cz;
      bit found;
      for (n = 0; n < count; n++) begin
         if (n % 110 == 0) begin
            win_x = window_origin();
            win_y = window_origin();
            win_z = window_origin();
         end
         r = $urandom_range(99);
         found = 1'b0;
         if (r < 5) begin
            queue_write($urandom_range(EDGE - 1), $urandom_range(EDGE - 1),
                        $urandom_range(EDGE - 1), $urandom_range((1 << VOXEL_W) - 1));
         end else begin
            if (r >= 50) begin
               for (tries = 0; tries < 12 && !found; tries++) begin
                  cx = win_x + $urandom_range(3);
                  cy = win_y + $urandom_range(3);
                  cz = win_z + $urandom_range(3);
                  found = queryable(cx, cy, cz);
               end
               if (found) begin
                  queue_query(cx, cy, cz);
               end
            end
            if (!found) begin
               for (tries = 0; tries < 6 && !found; tries++) begin
                  cx = win_x + $urandom_range(3);
                  cy = win_y + $urandom_range(3);
                  cz = win_z + $urandom_range(3);
                  found = !cell_filled[cell_index(cx, cy, cz)];
               end
               queue_write(cx, cy, cz, ($urandom_range(2) == 0) ?
                           0 : $urandom_range((1 << VOXEL_W) - 1, 1));
            end
         end
      end
   endtask

   // Request driver: a new item goes out at the falling edge only once the
   // previous transfer has completed, so tvalid never drops while waiting.
   always @(negedge clock) begin : request_driver
      voxel_req_type item;
      logic [REQ_W-1:0] word;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            item = pending_reqs.pop_front();
            word = '0;
            word[3*COORD_W+VOXEL_W-1:0] = {item.value, item.z, item.y, item.x};
            req_tvalid <= 1'b1;
            req_tdata <= word;
            req_tuser <= item.mode;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result backpressure, redrawn every cycle.
   always @(negedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // Monitor: checks each result transfer against the oldest outstanding
   // outcome, then updates the mirror or queues a new outcome for the
   // request transfer of the same edge. A result can never belong to a
   // query accepted at the same edge, so this order is safe.
   always @(posedge clock) begin : transfer_monitor
      cull_result_type want;
      cull_result_type got;
      int x, y, z;
      if (reset) begin
         req_fire <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.visible = rsp_tdata[0];
            got.vertex_word = rsp_tdata[VERTEX_W:1];
            if (vertex_due.size() == 0) begin
               $error("unexpected result transfer: visible %0d vertex word 0x%06h",
                      got.visible, got.vertex_word);
               errors++;
            end else begin
               want = vertex_due.pop_front();
               if (got.visible !== want.visible) begin
                  $error("visible mismatch: expected %0d, actual %0d",
                         want.visible, got.visible);
                  errors++;
               end
               if (got.vertex_word !== want.vertex_word) begin
                  $error("vertex word mismatch: expected 0x%06h, actual 0x%06h",
                         want.vertex_word, got.vertex_word);
                  errors++;
               end
               if (want.visible) begin
                  n_visible++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            x = int'(req_tdata[COORD_W-1:0]);
            y = int'(req_tdata[2*COORD_W-1:COORD_W]);
            z = int'(req_tdata[3*COORD_W-1:2*COORD_W]);
            if (req_tuser == MODE_WRITE) begin
               chunk_mirror[cell_index(x, y, z)] = req_tdata[3*COORD_W+VOXEL_W-1:3*COORD_W];
               n_writes++;
            end else begin
               vertex_due.insert(vertex_due.size(), cull_outcome(x, y, z));
               n_queries++;
            end
         end
         req_fire <= req_tvalid && req_tready;
         quiet_cycles <= ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) ?
                         0 : quiet_cycles + 1;
      end
   end

   // Watchdog: ends the run when neither channel has moved for too long.
   initial begin : watchdog
      while (quiet_cycles < STALL_LIMIT) begin
         @(negedge clock);
      end
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      int phase;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A solid cross: the centre has all six faces covered and stays hidden.
      queue_write(10, 10, 10, 255);
      queue_write(11, 10, 10, 1);
      queue_write(9, 10, 10, 2);
      queue_write(10, 11, 10, 4);
      queue_write(10, 9, 10, 8);
      queue_write(10, 10, 11, 16);
      queue_write(10, 10, 9, 128);
      queue_query(10, 10, 10);
      // Clearing one neighbor opens a face.
      queue_write(11, 10, 10, 0);
      queue_query(10, 10, 10);
      // An empty voxel is never visible, but its vertex word is still given.
      queue_write(10, 10, 10, 0);
      queue_query(10, 10, 10);
      // Corner voxels whose in-chunk neighbors are all solid: the faces on
      // the chunk boundary see empty space and make them visible.
      queue_write(0, 0, 0, 1);
      queue_write(1, 0, 0, 255);
      queue_write(0, 1, 0, 255);
      queue_write(0, 0, 1, 255);
      queue_query(0, 0, 0);
      queue_write(EDGE - 1, EDGE - 1, EDGE - 1, 170);
      queue_write(EDGE - 2, EDGE - 1, EDGE - 1, 85);
      queue_write(EDGE - 1, EDGE - 2, EDGE - 1, 85);
      queue_write(EDGE - 1, EDGE - 1, EDGE - 2, 85);
      queue_query(EDGE - 1, EDGE - 1, EDGE - 1);

      // Three phases of random traffic: sender mostly busy, then receiver
      // mostly busy, then both at full rate.
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 25;
               recv_idle_pct = 46;
            end
            1: begin
               send_idle_pct = 46;
               recv_idle_pct = 25;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         fill_random(ITEMS_PER_PHASE);
         while (pending_reqs.size() != 0 || req_tvalid) begin
            @(posedge clock);
         end
      end

      while (vertex_due.size() != 0) begin
         @(posedge clock);
      end
      // Leave room for any stray result the block might still produce.
      repeat (20) @(posedge clock);
      if (vertex_due.size() != 0) begin
         $error("%0d culling results never arrived", vertex_due.size());
         errors++;
      end

      $display("Drove %0d voxel writes and %0d visibility queries across three idle mixes.",
               n_writes, n_queries);
      $display("%0d queries found a visible voxel; %0d mismatches were seen.",
               n_visible, errors);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
